// File: hdl/ppk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppk_pkg: shared types and constants of the palette index bit packer
// Word and field widths, register indexes, the front-to-back item record,
// the result record and the entry-width helpers.
// ----------------------------------------------------------------------------
package ppk_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BITS_W     = 7;    // entry width, 1..64
    localparam int CNT_W      = 7;    // entries in one word, 1..64
    localparam int DONE_W     = 13;   // entries done in a stream
    localparam int PSIZE_W    = 17;
    localparam int MINB_W     = 5;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    localparam int DEFAULT_MAX_BITS    = 16;
    localparam int DEFAULT_MAX_ENTRIES = 4096;

    localparam logic [DONE_W-1:0] DONE_SAT = {DONE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BITS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 2'd3;

    localparam logic MODE_PACK   = 1'b0;
    localparam logic MODE_UNPACK = 1'b1;

    // One classified item, handed from the front end to the back end
    typedef struct packed {
        logic                 unpack;     // 1: unpack a word, 0: pack an index
        logic [WORD_BITS-1:0] data;
        logic [BITS_W-1:0]    bits;       // entry width of the stream
        logic [BITS_W-1:0]    ofs;        // pack: bit offset of the slot
        logic                 flush;      // pack: word goes out after this index
        logic [CNT_W-1:0]     n;          // unpack: indices to emit, >= 1
        logic                 end_flag;   // final result closes the stream
        logic                 short_flag; // unpack: stream ended early
    } ppk_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic                 run_last;
        logic                 stream_end;
        logic                 short_input;
    } ppk_result_t;

    // Entries per 64-bit word for a given entry width
    function automatic logic [CNT_W-1:0] epw_for(input logic [BITS_W-1:0] b);
        logic [CNT_W-1:0] r;
        if (b <= 7'd1)       r = 7'd64;
        else if (b == 7'd2)  r = 7'd32;
        else if (b == 7'd3)  r = 7'd21;
        else if (b == 7'd4)  r = 7'd16;
        else if (b == 7'd5)  r = 7'd12;
        else if (b == 7'd6)  r = 7'd10;
        else if (b == 7'd7)  r = 7'd9;
        else if (b == 7'd8)  r = 7'd8;
        else if (b == 7'd9)  r = 7'd7;
        else if (b == 7'd10) r = 7'd6;
        else if (b <= 7'd12) r = 7'd5;
        else if (b <= 7'd16) r = 7'd4;
        else if (b <= 7'd21) r = 7'd3;
        else if (b <= 7'd32) r = 7'd2;
        else                 r = 7'd1;
        return r;
    endfunction

    // Low-order mask of b ones; a width of 64 gives all ones
    function automatic logic [WORD_BITS-1:0] entry_mask(input logic [BITS_W-1:0] b);
        return ~({WORD_BITS{1'b1}} << b);
    endfunction

endpackage

// File: hdl/ppk_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppk_fifo: small register queue
// Flop-based first-in first-out buffer; push only when not full, pop only
// when not empty. Head is shown combinationally from the stored entries.
// ----------------------------------------------------------------------------
module ppk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/ppk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppk_front: configuration registers and item classification
// Holds the registers, latches the entry width at stream start, tracks slot
// offset and entries done, and turns each item into a queue record.
// ----------------------------------------------------------------------------
module ppk_front
    import ppk_pkg::*;
#(
    parameter int MAX_BITS    = DEFAULT_MAX_BITS,
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [WORD_BITS-1:0]  data_in,
    input  logic                  stream_last,
    output logic                  q_push,
    output ppk_item_t             q_item,
    output logic                  clear
);

    logic                 mode_reg;
    logic [PSIZE_W-1:0]   psize_reg;
    logic [MINB_W-1:0]    minb_reg;
    logic [DONE_W-1:0]    ecount_reg;
    logic [BITS_W-1:0]    bits_reg;
    logic [CNT_W-1:0]     epw_reg;
    logic [BITS_W-1:0]    ofs_reg, ofs_next;
    logic [DONE_W-1:0]    done_reg, done_next;

    logic [PSIZE_W-1:0]   ps_m1;
    logic [BITS_W-1:0]    clog;
    logic [BITS_W-1:0]    bits_new;
    logic                 start;
    logic [BITS_W-1:0]    bits_cur;
    logic [CNT_W-1:0]     epw_cur;
    logic [BITS_W:0]      sum;
    logic [BITS_W:0]      sum2;
    logic [DONE_W-1:0]    target;
    logic [DONE_W-1:0]    rem;

    assign clear = cfg_we && (cfg_index == REG_MODE) && (cfg_data[0] != mode_reg);

    // Entry width from the registers: max(ceil(log2 size), min_bits), capped
    always_comb
    begin
        ps_m1 = psize_reg - 1'b1;
        clog  = '0;
        if (psize_reg > PSIZE_W'(1))
        begin
            for (int i = 0; i < PSIZE_W; i++)
            begin
                if (ps_m1[i])
                begin
                    clog = BITS_W'(i + 1);
                end
            end
        end
        bits_new = clog;
        if (bits_new < BITS_W'(minb_reg))
        begin
            bits_new = BITS_W'(minb_reg);
        end
        if (bits_new > BITS_W'(MAX_BITS))
        begin
            bits_new = BITS_W'(MAX_BITS);
        end
        if (bits_new == '0)
        begin
            bits_new = BITS_W'(1);
        end
    end

    assign start    = (ofs_reg == '0) && (done_reg == '0);
    assign bits_cur = start ? bits_new : bits_reg;
    assign epw_cur  = start ? epw_for(bits_new) : epw_reg;
    assign target   = (32'(ecount_reg) > MAX_ENTRIES) ? DONE_W'(MAX_ENTRIES) : ecount_reg;
    assign rem      = target - done_reg;

    always_comb
    begin
        sum  = {1'b0, ofs_reg} + {1'b0, bits_cur};
        sum2 = sum + {1'b0, bits_cur};

        q_item            = '0;
        q_item.unpack     = mode_reg;
        q_item.data       = data_in;
        q_item.bits       = bits_cur;
        q_item.ofs        = ofs_reg;
        q_push            = 1'b0;
        ofs_next          = ofs_reg;
        done_next         = done_reg;

        if (mode_reg == MODE_PACK)
        begin
            q_push       = accept;
            // next slot would not fit: word is full
            q_item.flush    = (sum2 > (BITS_W + 1)'(WORD_BITS)) || stream_last;
            q_item.end_flag = stream_last;
            if (accept)
            begin
                ofs_next = q_item.flush ? '0 : sum[BITS_W-1:0];
                if (stream_last)
                begin
                    done_next = '0;
                end
                else if (done_reg != DONE_SAT)
                begin
                    done_next = done_reg + 1'b1;
                end
            end
        end
        else
        begin
            // zero entry count: item is taken and dropped
            q_push = accept && (target != '0);
            if (done_reg >= target)
            begin
                // count lowered mid-stream: one index closes it
                q_item.n        = CNT_W'(1);
                q_item.end_flag = 1'b1;
                done_next       = '0;
            end
            else if (rem <= DONE_W'(epw_cur))
            begin
                q_item.n        = rem[CNT_W-1:0];
                q_item.end_flag = 1'b1;
                done_next       = '0;
            end
            else
            begin
                q_item.n = epw_cur;
                if (stream_last)
                begin
                    q_item.end_flag   = 1'b1;
                    q_item.short_flag = 1'b1;
                    done_next         = '0;
                end
                else
                begin
                    done_next = done_reg + DONE_W'(epw_cur);
                end
            end
            if (!q_push)
            begin
                done_next = done_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PACK;
            psize_reg  <= PSIZE_W'(1);
            minb_reg   <= MINB_W'(4);
            ecount_reg <= DONE_W'(4096);
            ofs_reg    <= '0;
            done_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:         mode_reg   <= cfg_data[0];
                    REG_PALETTE_SIZE: psize_reg  <= cfg_data[PSIZE_W-1:0];
                    REG_MIN_BITS:     minb_reg   <= cfg_data[MINB_W-1:0];
                    REG_ENTRY_COUNT:  ecount_reg <= cfg_data[DONE_W-1:0];
                    default:          ;
                endcase
            end
            if (clear)
            begin
                ofs_reg  <= '0;
                done_reg <= '0;
            end
            else
            begin
                ofs_reg  <= ofs_next;
                done_reg <= done_next;
            end
        end
    end

    // width is latched on the first item of a stream
    always_ff @(posedge clk)
    begin
        if (accept && start)
        begin
            bits_reg <= bits_new;
            epw_reg  <= epw_for(bits_new);
        end
    end

endmodule

// File: hdl/ppk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppk_back: pack accumulator and unpack slot sequencer
// Packs indices into the accumulator, or walks a word one slot per cycle while
// the output queue has room, and writes results into the output queue.
// ----------------------------------------------------------------------------
module ppk_back
    import ppk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        q_empty,
    input  ppk_item_t   q_head,
    output logic        q_pop,
    input  logic        o_full,
    output logic        o_push,
    output ppk_result_t o_res
);

    logic                 busy_reg, busy_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BITS_W-1:0]    bits_reg, bits_next;
    logic                 end_reg, end_next;
    logic                 short_reg, short_next;

    logic                 final_res;
    logic [WORD_BITS-1:0] packed_val;

    always_comb
    begin
        busy_next  = busy_reg;
        acc_next   = acc_reg;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        end_next   = end_reg;
        short_next = short_reg;
        q_pop      = 1'b0;
        o_push     = 1'b0;
        o_res      = '0;
        final_res  = 1'b0;
        packed_val = acc_reg | ((q_head.data & entry_mask(q_head.bits)) << q_head.ofs);

        if (busy_reg)
        begin
            if (!o_full)
            begin
                final_res         = (cnt_reg == CNT_W'(1));
                o_push            = 1'b1;
                o_res.data        = word_reg & entry_mask(bits_reg);
                o_res.run_last    = final_res;
                o_res.stream_end  = final_res && end_reg;
                o_res.short_input = final_res && short_reg;
                word_next         = word_reg >> bits_reg;
                cnt_next          = cnt_reg - 1'b1;
                busy_next         = !final_res;
            end
        end
        else if (!q_empty && !o_full)
        begin
            q_pop = 1'b1;
            if (q_head.unpack)
            begin
                final_res         = (q_head.n == CNT_W'(1));
                o_push            = 1'b1;
                o_res.data        = q_head.data & entry_mask(q_head.bits);
                o_res.run_last    = final_res;
                o_res.stream_end  = final_res && q_head.end_flag;
                o_res.short_input = final_res && q_head.short_flag;
                busy_next         = !final_res;
                word_next         = q_head.data >> q_head.bits;
                cnt_next          = q_head.n - 1'b1;
                bits_next         = q_head.bits;
                end_next          = q_head.end_flag;
                short_next        = q_head.short_flag;
            end
            else if (q_head.flush)
            begin
                o_push           = 1'b1;
                o_res.data       = packed_val;
                o_res.run_last   = 1'b1;
                o_res.stream_end = q_head.end_flag;
                acc_next         = '0;
            end
            else
            begin
                acc_next = packed_val;
            end
        end

        if (clear)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        cnt_reg   <= cnt_next;
        bits_reg  <= bits_next;
        end_reg   <= end_next;
        short_reg <= short_next;
    end

endmodule

// File: hdl/palette_index_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_index_bit_packer: fixed-width palette index packer / unpacker
// Packs indices into 64-bit words with no entry spanning two words, or
// unpacks words back into indices, with stream end and short flags.
// ----------------------------------------------------------------------------
// Path: a taken item is registered in the item queue and its results in the
//   result queue before the first of them shows on the output.
// Throughput: pack mode takes one item per cycle unless the item queue is full;
//   unpack mode gives one index per cycle unless the result queue is full.
// Reset: rst_n clears both queues, stream state and the accumulator at once,
//   and returns the registers to pack, size 1, min 4 bits, count 4096.
// ----------------------------------------------------------------------------
module palette_index_bit_packer
    import ppk_pkg::*;
#(
    parameter int MAX_BITS    = DEFAULT_MAX_BITS,
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  push,
    output logic                  full,
    input  logic [WORD_BITS-1:0]  data_in,
    input  logic                  stream_last,
    // results
    output logic                  empty,
    input  logic                  pop,
    output logic [WORD_BITS-1:0]  data_out,
    output logic                  run_last,
    output logic                  stream_end,
    output logic                  short_input
);

    // Front end -> item queue
    logic        accept;
    logic        q_push;
    ppk_item_t   q_item;
    logic        clear;

    // Item queue -> back end
    logic        q_empty;
    logic        q_pop;
    ppk_item_t   q_head;

    // Back end -> result queue
    logic        o_full;
    logic        o_push;
    ppk_result_t o_res;
    ppk_result_t o_head;

    // An item is taken whenever the item queue has room; the front end
    // decides whether it produces a queue record (a zero entry count in
    // unpack mode drops it).
    assign accept = push && !full;

    ppk_front #(
        .MAX_BITS    (MAX_BITS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .data_in     (data_in),
        .stream_last (stream_last),
        .q_push      (q_push),
        .q_item      (q_item),
        .clear       (clear)
    );

    // Two-entry queue between classification and execution: the front keeps
    // taking items while the back end walks a multi-index word.
    ppk_fifo #(
        .WIDTH ($bits(ppk_item_t)),
        .DEPTH (2)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_item),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (full),
        .empty   (q_empty)
    );

    ppk_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_res   (o_res)
    );

    // Result queue decouples the back end from a stalled consumer.
    ppk_fifo #(
        .WIDTH ($bits(ppk_result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_push),
        .wr_data (o_res),
        .rd_en   (pop),
        .rd_data (o_head),
        .full    (o_full),
        .empty   (empty)
    );

    assign data_out    = o_head.data;
    assign run_last    = o_head.run_last;
    assign stream_end  = o_head.stream_end;
    assign short_input = o_head.short_input;

endmodule

// File: hdl/ppk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppk_port_checks: port-level checks of the palette index bit packer
// Flag consistency of results and result-side hold behavior.
// ----------------------------------------------------------------------------
module ppk_port_checks
    import ppk_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input logic [WORD_BITS-1:0]  data_out,
    input logic                  run_last,
    input logic                  stream_end,
    input logic                  short_input
);

    a_short_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && short_input) |-> stream_end)
        else $error("short_input without stream_end");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_end) |-> run_last)
        else $error("stream_end on a result that is not last of its item");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting item vanished");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(data_out) && $stable(run_last)
                              && $stable(stream_end) && $stable(short_input)))
        else $error("waiting item changed");

endmodule

bind palette_index_bit_packer ppk_port_checks u_ppk_port_checks (.*);
